// File: src/mwf_pkg.sv
// Shared constants for the median window filter.
package mwf_pkg;
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_WINDOW_DEF = 9;
  localparam int unsigned MAX_HEIGHT     = 4096;
  localparam logic [10:0] WIDTH_RST      = 11'd640;
  localparam logic [12:0] HEIGHT_RST     = 13'd480;
  localparam logic [3:0]  WINDOW_RST     = 4'd3;
  localparam logic [1:0]  REG_WIDTH      = 2'd0;
  localparam logic [1:0]  REG_HEIGHT     = 2'd1;
  localparam logic [1:0]  REG_WINDOW     = 2'd2;
endpackage

// File: src/median_window_filter.sv
// Streaming 2-D median filter: line store, window gather, bit-plane median.
//
// Usage: pixels of a frame enter in raster order on in_valid/in_pixel; an
// input request is taken when in_valid is high and in_stall is low. For each
// window center whose k-by-k window lies inside the frame a result request
// carries out_median, out_center_row, out_center_col and out_frame_last; it
// is taken when out_valid is high and out_stall is low. Border pixels give
// no result. Frame size and window size are written on the cfg_ port while
// the block is idle.
// Operation: a producing pixel gathers its k*k window pixels from the line
// store, one memory read per cycle, and runs eight bit-plane passes over the
// window with one shared compare-and-count unit; input is stalled until its
// result is in the output register. A border pixel does not stall input.
// The result sits in an output register; the block accepts the next pixel
// while it waits; a new result waits in S_DONE, stalling input, until it is taken.
// Reset clears counters, control and registers (640, 480, 3); the line store
// needs no clearing since entries are read only after being written.
module median_window_filter #(
  parameter int unsigned MAX_WIDTH  = mwf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_WINDOW = mwf_pkg::MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_median,
  output logic [11:0] out_center_row,
  output logic [9:0]  out_center_col,
  output logic        out_frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  localparam int unsigned RW   = $clog2(MAX_WINDOW);
  localparam int unsigned WN   = MAX_WINDOW * MAX_WINDOW;
  localparam int unsigned NW   = $clog2(WN + 1);
  localparam int unsigned AW   = $clog2(MAX_WINDOW * MAX_WIDTH);
  localparam int unsigned KMAX = (MAX_WINDOW - 1) | 1;

  typedef enum logic [2:0] {S_IDLE, S_GATHER, S_COUNT, S_DONE} state_t;

  state_t            state_r;
  logic [10:0]       width_r;
  logic [12:0]       height_r;
  logic [3:0]        window_r;
  logic [11:0]       row_r;
  logic [RW-1:0]     rmod_r;
  logic [12:0]       col_r;
  logic [7:0]        store [MAX_WINDOW*MAX_WIDTH];
  logic [7:0]        win_r [WN];
  logic [7:0]        rd_r;
  logic [7:0]        wv_r;
  logic              wv_vld_r;
  logic [3:0]        gj_r;
  logic [3:0]        k_r;
  logic [NW-1:0]     n_r, idx_r, below_r;
  logic              rd_vld_r;
  logic [NW-1:0]     wr_ptr_r;
  logic [RW-1:0]     grow_r;
  logic [12:0]       gcol_r;
  logic [2:0]        bit_r;
  logic [7:0]        res_r;
  logic [11:0]       crow_r;
  logic [9:0]        ccol_r;
  logic              last_r;
  logic              out_valid_r;
  logic [7:0]        med_r;
  logic [11:0]       orow_r;
  logic [9:0]        ocol_r;
  logic              olast_r;

  // effective configuration
  logic [12:0] w_eff, h_eff;
  logic [3:0]  k_eff;
  always_comb begin
    w_eff = {2'b0, width_r};
    if (w_eff == '0) w_eff = 13'd1;
    if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
    h_eff = height_r;
    if (h_eff == '0) h_eff = 13'd1;
    if (h_eff > 13'(mwf_pkg::MAX_HEIGHT)) h_eff = 13'(mwf_pkg::MAX_HEIGHT);
    k_eff = window_r | 4'd1;
    if (k_eff > 4'(KMAX)) k_eff = 4'(KMAX);
  end

  // position of the incoming pixel after wrap
  logic [12:0] c_cur;
  logic [12:0] r_cur;
  logic [12:0] c_inc;
  logic [12:0] r_inc;
  logic [RW-1:0] r_mod;
  logic [RW-1:0] rm_inc;
  logic [RW:0]   gstart;
  logic [RW-1:0] g_first;
  logic        produce;
  always_comb begin
    c_cur = col_r;
    r_cur = {1'b0, row_r};
    r_mod = rmod_r;
    if (c_cur >= w_eff) begin
      c_cur = '0;
      r_cur = r_cur + 13'd1;
      r_mod = (r_mod == RW'(MAX_WINDOW - 1)) ? '0 : r_mod + RW'(1);
    end
    if (r_cur >= h_eff) begin
      r_cur = '0;
      r_mod = '0;
    end
    produce = (r_cur + 13'd1 >= 13'(k_eff)) && (c_cur + 13'd1 >= 13'(k_eff));
    c_inc   = c_cur + 13'd1;
    r_inc   = r_cur;
    rm_inc  = r_mod;
    if (c_inc >= w_eff) begin
      c_inc  = '0;
      r_inc  = r_cur + 13'd1;
      rm_inc = (r_mod == RW'(MAX_WINDOW - 1)) ? '0 : r_mod + RW'(1);
      if (r_inc >= h_eff) begin
        r_inc  = '0;
        rm_inc = '0;
      end
    end
    // first window row r+1-k, folded into the store depth
    gstart  = {1'b0, r_mod} + (RW+1)'(MAX_WINDOW + 1) - (RW+1)'(k_eff);
    g_first = (gstart >= (RW+1)'(MAX_WINDOW)) ?
              RW'(gstart - (RW+1)'(MAX_WINDOW)) : gstart[RW-1:0];
  end

  logic in_take;
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);

  // one compare per cycle against the trial value
  logic [7:0] trial;
  assign trial = res_r | (8'd1 << bit_r);

  logic [AW-1:0] rd_addr;
  assign rd_addr = AW'(grow_r * MAX_WIDTH) + AW'(gcol_r);

  always_ff @(posedge clk) begin
    if (in_take) store[AW'(r_mod * MAX_WIDTH) + AW'(c_cur)] <= in_pixel;
    rd_r <= store[rd_addr];
    if (rd_vld_r) win_r[wr_ptr_r] <= rd_r;
    wv_r <= win_r[idx_r];
  end

  logic [RW:0] grow_sum;
  assign grow_sum = {1'b0, grow_r} + {{RW{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= mwf_pkg::WIDTH_RST;
      height_r    <= mwf_pkg::HEIGHT_RST;
      window_r    <= mwf_pkg::WINDOW_RST;
      row_r       <= '0;
      rmod_r      <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mwf_pkg::REG_WIDTH:  width_r  <= cfg_data[10:0];
          mwf_pkg::REG_HEIGHT: height_r <= cfg_data;
          mwf_pkg::REG_WINDOW: window_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            col_r  <= c_inc;
            row_r  <= r_inc[11:0];
            rmod_r <= rm_inc;
            if (produce) begin
              k_r      <= k_eff;
              n_r      <= NW'(k_eff) * NW'(k_eff);
              crow_r   <= 12'(r_cur - 13'(k_eff >> 1));
              ccol_r   <= 10'(c_cur - 13'(k_eff >> 1));
              last_r   <= (r_cur == h_eff - 13'd1) && (c_cur == w_eff - 13'd1);
              grow_r   <= g_first;
              gcol_r   <= c_cur + 13'd1 - 13'(k_eff);
              gj_r     <= '0;
              idx_r    <= '0;
              wr_ptr_r <= '0;
              rd_vld_r <= 1'b0;
              state_r  <= S_GATHER;
            end
          end
        end
        S_GATHER: begin
          // rd_r is the registered read of the address; rd_vld_r tracks that
          if (rd_vld_r) wr_ptr_r <= wr_ptr_r + NW'(1);
          if (idx_r < n_r) begin
            rd_vld_r <= 1'b1;
            idx_r    <= idx_r + NW'(1);
            if (gj_r == k_r - 4'd1) begin
              gj_r   <= '0;
              gcol_r <= gcol_r + 13'd1 - 13'(k_r);
              grow_r <= (grow_sum == (RW+1)'(MAX_WINDOW)) ? '0 : grow_sum[RW-1:0];
            end else begin
              gj_r   <= gj_r + 4'd1;
              gcol_r <= gcol_r + 13'd1;
            end
          end else begin
            rd_vld_r <= 1'b0;
            if (!rd_vld_r) begin
              idx_r    <= '0;
              below_r  <= '0;
              bit_r    <= 3'd7;
              res_r    <= '0;
              wv_vld_r <= 1'b0;
              state_r  <= S_COUNT;
            end
          end
        end
        S_COUNT: begin
          // wv_r is registered from idx_r, same as the gather read
          if (wv_vld_r && wv_r < trial) below_r <= below_r + NW'(1);
          if (idx_r < n_r) begin
            wv_vld_r <= 1'b1;
            idx_r    <= idx_r + NW'(1);
          end else begin
            wv_vld_r <= 1'b0;
            if (!wv_vld_r) begin
              if (below_r <= (n_r >> 1)) res_r <= trial;
              idx_r   <= '0;
              below_r <= '0;
              if (bit_r == 3'd0) state_r <= S_DONE;
              else bit_r <= bit_r - 3'd1;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            med_r       <= res_r;
            orow_r      <= crow_r;
            ocol_r      <= ccol_r;
            olast_r     <= last_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_median     = med_r;
  assign out_center_row = orow_r;
  assign out_center_col = ocol_r;
  assign out_frame_last = olast_r;

`ifndef NO_ASSERTIONS
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COUNT) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_median)))
    else $error("stalled result changed");
  a_done_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_stall) |=> out_valid) else $error("result lost");
`endif
endmodule

// File: test/median_window_filter_tb.sv
// Self-checking testbench for the streaming 2-D median window filter.
`timescale 1ns / 1ps

module median_window_filter_tb;

  localparam int unsigned LW = mwf_pkg::MAX_WIDTH_DEF;
  localparam int unsigned LK = mwf_pkg::MAX_WINDOW_DEF;

  typedef struct packed {
    logic [7:0]  med;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } median_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_pixel;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_median;
  logic [11:0] out_center_row;
  logic [9:0]  out_center_col;
  logic        out_frame_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  logic rand_stall;
  logic hold_stall;
  logic quiet;
  event hold_go;

  // predictor state
  logic [7:0]  rows_seen [LK][LW];
  logic [10:0] cur_width;
  logic [12:0] cur_height;
  logic [3:0]  cur_window;
  int unsigned row_pos;
  int unsigned col_pos;
  median_t     medians_due[$];

  int unsigned mismatches;
  int unsigned medians_checked;
  int unsigned pixels_sent;
  int unsigned frames_sent;

  assign out_stall = rand_stall | hold_stall;

  median_window_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_stall(out_stall), .out_median(out_median),
    .out_center_row(out_center_row), .out_center_col(out_center_col),
    .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = cur_width;
    if (w == 0) w = 1;
    if (w > LW) w = LW;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = cur_height;
    if (h == 0) h = 1;
    if (h > mwf_pkg::MAX_HEIGHT) h = mwf_pkg::MAX_HEIGHT;
    return h;
  endfunction

  function automatic int unsigned eff_window();
    int unsigned k;
    k = cur_window | 4'd1;
    if (k > ((LK - 1) | 1)) k = (LK - 1) | 1;
    return k;
  endfunction

  // Advance the frame position by one pixel and queue the median it yields.
  task automatic track_pixel(input logic [7:0] p);
    int unsigned w, h, k, half, n, acc, v;
    int unsigned hist [256];
    median_t m;
    w = eff_width();
    h = eff_height();
    k = eff_window();
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    rows_seen[row_pos % LK][col_pos] = p;
    if (row_pos + 1 >= k && col_pos + 1 >= k) begin
      half = k / 2;
      n = k * k;
      for (int i = 0; i < 256; i++) hist[i] = 0;
      for (int i = 0; i < k; i++)
        for (int j = 0; j < k; j++)
          hist[rows_seen[(row_pos + 1 - k + i) % LK][col_pos + 1 - k + j]]++;
      acc = 0;
      v = 0;
      while (acc + hist[v] <= n / 2) begin
        acc += hist[v];
        v++;
      end
      m.med  = v[7:0];
      m.row  = 12'(row_pos - half);
      m.col  = 10'(col_pos - half);
      m.last = (row_pos == h - 1 && col_pos == w - 1);
      medians_due.push_back(m);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic send_pixel(input logic [7:0] p);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (in_stall);
    track_pixel(p);
    pixels_sent++;
  endtask

  // Drain pending medians; border pixels yield none, so nothing else is in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  // Upper data bits beyond the register width are randomized to test masking.
  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    logic [12:0] junk;
    junk = 13'($urandom);
    case (idx)
      mwf_pkg::REG_WIDTH:  val = (junk & 13'h1800) | val;
      mwf_pkg::REG_WINDOW: val = (junk & 13'h1FF0) | val;
      default: ;
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mwf_pkg::REG_WIDTH:  cur_width  = val[10:0];
      mwf_pkg::REG_HEIGHT: cur_height = val;
      mwf_pkg::REG_WINDOW: cur_window = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned k);
    wait_idle();
    write_reg(mwf_pkg::REG_WIDTH, 13'(w));
    write_reg(mwf_pkg::REG_HEIGHT, 13'(h));
    write_reg(mwf_pkg::REG_WINDOW, 13'(k));
  endtask

  // mode 0: full range, mode 1: narrow range with many ties, mode 2: extremes only
  task automatic send_frame(input int unsigned mode);
    int unsigned n;
    logic [7:0] base;
    n = eff_width() * eff_height();
    base = 8'($urandom);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: send_pixel(8'($urandom));
        1: send_pixel(base + 8'($urandom_range(0, 3)));
        default: send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00);
      endcase
    end
    frames_sent++;
  endtask

  task automatic test_directed_extremes();
    set_frame(5, 5, 3);
    for (int i = 0; i < 25; i++)
      send_pixel((i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'(i * 37));
    frames_sent++;
  endtask

  task automatic test_odd_settings();
    set_frame(0, 0, 0);     // one-pixel frame, window of one
    send_frame(0);
    send_frame(2);
    set_frame(4, 4, 5);     // window larger than frame: no medians
    send_frame(0);
    set_frame(6, 6, 4);     // even window rounds up
    send_frame(1);
    set_frame(10, 9, 15);   // oversize window clamps to the maximum
    send_frame(0);
    set_frame(2047, 0, 0);  // width saturates to full line
    send_frame(0);
  endtask

  // Tallest frame: run part way in, then shrink height so the row wraps cleanly.
  task automatic test_tall_frame();
    set_frame(3, 4096, 1);
    for (int i = 0; i < 30; i++) send_pixel(8'($urandom));
    wait_idle();
    write_reg(mwf_pkg::REG_HEIGHT, 13'd10);
    send_frame(0);
  endtask

  task automatic test_backpressure();
    set_frame(8, 8, 3);
    quiet = 1'b1;
    ->hold_go;
    send_frame(0);
    quiet = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned w, h, k;
    while (pixels_sent < 1850) begin
      if ($urandom_range(0, 7) == 0) begin
        k = 9;
        w = $urandom_range(9, 11);
        h = $urandom_range(9, 10);
      end else begin
        k = 2 * $urandom_range(0, 3) + 1;
        w = $urandom_range(3, 16);
        h = $urandom_range(3, 12);
      end
      set_frame(w, h, k);
      quiet = ($urandom_range(0, 4) == 0);
      send_frame($urandom_range(0, 2));
    end
    quiet = 1'b0;
  endtask

  initial begin
    rand_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet) begin
        rand_stall <= 1'b1;
        repeat ($urandom_range(0, 17)) @(posedge clk);
      end
      rand_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    hold_stall = 1'b0;
    forever begin
      @(hold_go);
      hold_stall <= 1'b1;
      repeat (400) @(posedge clk);
      hold_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    median_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (medians_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: median %0d row %0d col %0d last %0d",
                   out_median, out_center_row, out_center_col, out_frame_last);
      end else begin
        want = medians_due.pop_front();
        medians_checked++;
        if (want.med !== out_median || want.row !== out_center_row ||
            want.col !== out_center_col || want.last !== out_frame_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp med %0d r %0d c %0d l %0d, got %0d %0d %0d %0d",
                     want.med, want.row, want.col, want.last, out_median,
                     out_center_row, out_center_col, out_frame_last);
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = mwf_pkg::REG_WIDTH;
    cfg_data = 13'h0;
    quiet = 1'b0;
    cur_width = mwf_pkg::WIDTH_RST;
    cur_height = mwf_pkg::HEIGHT_RST;
    cur_window = mwf_pkg::WINDOW_RST;
    row_pos = 0;
    col_pos = 0;
    mismatches = 0;
    medians_checked = 0;
    pixels_sent = 0;
    frames_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_odd_settings();
    test_tall_frame();
    test_backpressure();
    test_random_frames();

    in_valid <= 1'b0;
    waited = 0;
    while (medians_due.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (1000) @(posedge clk);
    if (medians_due.size() != 0) begin
      mismatches++;
      $display("%0d expected medians never arrived", medians_due.size());
    end
    $display("Sent %0d pixels in %0d frames, checked %0d medians, %0d mismatches.",
             pixels_sent, frames_sent, medians_checked, mismatches);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
